[rtl/core/rvid_pkg.sv]
package rvid_pkg;

   // instruction identity, numbered as the decoder reports it
   typedef enum logic [5:0] {
      ID_UNKNOWN, ID_LUI, ID_AUIPC, ID_JAL, ID_JALR,
      ID_BEQ, ID_BNE, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU,
      ID_LB, ID_LH, ID_LW, ID_LBU, ID_LHU,
      ID_SB, ID_SH, ID_SW,
      ID_ADDI, ID_SLTI, ID_SLTIU, ID_XORI, ID_ORI, ID_ANDI,
      ID_SLLI, ID_SRLI, ID_SRAI,
      ID_ADD, ID_SUB, ID_SLL, ID_SLT, ID_SLTU, ID_XOR,
      ID_SRL, ID_SRA, ID_OR, ID_AND,
      ID_FENCE, ID_ECALL, ID_EBREAK,
      ID_LWU, ID_LD, ID_SD,
      ID_ADDIW, ID_SLLIW, ID_SRLIW, ID_SRAIW,
      ID_ADDW, ID_SUBW, ID_SLLW, ID_SRLW, ID_SRAW,
      ID_MRET,
      ID_CSRRW, ID_CSRRS, ID_CSRRC, ID_CSRRWI, ID_CSRRSI, ID_CSRRCI
   } ins_code_type;

   typedef enum logic [2:0] {
      FMT_NONE, FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J
   } fmt_type;

   localparam logic [6:0] OP_LOAD     = 7'd3;
   localparam logic [6:0] OP_MISC_MEM = 7'd15;
   localparam logic [6:0] OP_OP_IMM   = 7'd19;
   localparam logic [6:0] OP_AUIPC    = 7'd23;
   localparam logic [6:0] OP_OP_IMM32 = 7'd27;
   localparam logic [6:0] OP_STORE    = 7'd35;
   localparam logic [6:0] OP_OP       = 7'd51;
   localparam logic [6:0] OP_LUI      = 7'd55;
   localparam logic [6:0] OP_OP32     = 7'd59;
   localparam logic [6:0] OP_BRANCH   = 7'd99;
   localparam logic [6:0] OP_JALR     = 7'd103;
   localparam logic [6:0] OP_JAL      = 7'd111;
   localparam logic [6:0] OP_SYSTEM   = 7'd115;

   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SRL_SRA = 3'd5;

   localparam logic [11:0] F12_ECALL = 12'd0;
   localparam logic [11:0] F12_MRET  = 12'd770;

   localparam int WORD_W = 32;
   localparam int IMM_W  = 20;
   localparam int RSP_W  = 64;

   typedef struct packed {
      ins_code_type code;
      fmt_type      fmt;
   } dec_type;

   typedef struct packed {
      logic [IMM_W-1:0] immediate;
      logic [4:0]       src_reg2;
      logic [4:0]       src_reg1;
      logic [4:0]       dest_reg;
      logic [6:0]       func7;
      logic [2:0]       func3;
      logic [6:0]       major_opcode;
      fmt_type          fmt;
      ins_code_type     code;
   } rsp_fields_type;

   function automatic ins_code_type load_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd0: c = ID_LB;
         3'd1: c = ID_LH;
         3'd2: c = ID_LW;
         3'd3: c = ID_LD;
         3'd4: c = ID_LBU;
         3'd5: c = ID_LHU;
         3'd6: c = ID_LWU;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ins_code_type opimm_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd0: c = ID_ADDI;
         3'd1: c = ID_SLLI;
         3'd2: c = ID_SLTI;
         3'd3: c = ID_SLTIU;
         3'd4: c = ID_XORI;
         3'd6: c = ID_ORI;
         3'd7: c = ID_ANDI;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ins_code_type store_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd0: c = ID_SB;
         3'd1: c = ID_SH;
         3'd2: c = ID_SW;
         3'd3: c = ID_SD;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ins_code_type op_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd1: c = ID_SLL;
         3'd2: c = ID_SLT;
         3'd3: c = ID_SLTU;
         3'd4: c = ID_XOR;
         3'd6: c = ID_OR;
         3'd7: c = ID_AND;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ins_code_type branch_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd0: c = ID_BEQ;
         3'd1: c = ID_BNE;
         3'd4: c = ID_BLT;
         3'd5: c = ID_BGE;
         3'd6: c = ID_BLTU;
         3'd7: c = ID_BGEU;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ins_code_type csr_code(input logic [2:0] f3);
      ins_code_type c;
      unique case (f3)
         3'd1: c = ID_CSRRW;
         3'd2: c = ID_CSRRS;
         3'd3: c = ID_CSRRC;
         3'd5: c = ID_CSRRWI;
         3'd6: c = ID_CSRRSI;
         3'd7: c = ID_CSRRCI;
         default: c = ID_UNKNOWN;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/rvid_classify.sv]
module rvid_classify (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [rvid_pkg::WORD_W-1:0] in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rvid_pkg::WORD_W-1:0] out_word,
   output rvid_pkg::dec_type          out_dec
);
   import rvid_pkg::*;

   logic                valid_ff;
   logic [WORD_W-1:0]   word_ff;
   dec_type             dec_ff;
   dec_type             dec_in;
   logic [6:0]          op;
   logic [2:0]          f3;
   logic [6:0]          f7;
   logic [11:0]         f12;

   assign op  = in_word[6:0];
   assign f3  = in_word[14:12];
   assign f7  = in_word[31:25];
   assign f12 = in_word[31:20];

   always_comb begin
      dec_in.code = ID_UNKNOWN;
      dec_in.fmt  = FMT_NONE;
      unique case (op)
         OP_LOAD: begin
            dec_in.code = load_code(f3);
            dec_in.fmt  = FMT_I;
         end
         OP_MISC_MEM: dec_in.code = ID_FENCE;
         OP_OP_IMM: begin
            if (f3 == F3_SRL_SRA) begin
               dec_in.code = (f7[6:1] == 6'd0) ? ID_SRLI : ID_SRAI;
            end else begin
               dec_in.code = opimm_code(f3);
            end
            dec_in.fmt = (f3 == F3_SLL || f3 == F3_SRL_SRA) ? FMT_R : FMT_I;
         end
         OP_AUIPC: begin
            dec_in.code = ID_AUIPC;
            dec_in.fmt  = FMT_U;
         end
         OP_OP_IMM32: begin
            if (f3 == F3_ADD_SUB) begin
               dec_in.code = ID_ADDIW;
               dec_in.fmt  = FMT_I;
            end else if (f3 == F3_SLL) begin
               dec_in.code = ID_SLLIW;
               dec_in.fmt  = FMT_R;
            end else if (f3 == F3_SRL_SRA) begin
               dec_in.code = (f7 == 7'd0) ? ID_SRLIW : ID_SRAIW;
               dec_in.fmt  = FMT_R;
            end
         end
         OP_STORE: begin
            dec_in.code = store_code(f3);
            dec_in.fmt  = FMT_S;
         end
         OP_OP: begin
            if (f3 == F3_ADD_SUB) begin
               dec_in.code = (f7 == 7'd0) ? ID_ADD : ID_SUB;
            end else if (f3 == F3_SRL_SRA) begin
               dec_in.code = (f7 == 7'd0) ? ID_SRL : ID_SRA;
            end else begin
               dec_in.code = op_code(f3);
            end
            dec_in.fmt = FMT_R;
         end
         OP_LUI: begin
            dec_in.code = ID_LUI;
            dec_in.fmt  = FMT_U;
         end
         OP_OP32: begin
            if (f3 == F3_ADD_SUB) begin
               dec_in.code = (f7 == 7'd0) ? ID_ADDW : ID_SUBW;
            end else if (f3 == F3_SLL) begin
               dec_in.code = ID_SLLW;
            end else if (f3 == F3_SRL_SRA) begin
               dec_in.code = (f7 == 7'd0) ? ID_SRLW : ID_SRAW;
            end
            dec_in.fmt = FMT_R;
         end
         OP_BRANCH: begin
            dec_in.code = branch_code(f3);
            dec_in.fmt  = FMT_B;
         end
         OP_JALR: begin
            dec_in.code = ID_JALR;
            dec_in.fmt  = FMT_I;
         end
         OP_JAL: begin
            dec_in.code = ID_JAL;
            dec_in.fmt  = FMT_J;
         end
         OP_SYSTEM: begin
            if (f3 == 3'd0) begin
               if (f12 == F12_ECALL) begin
                  dec_in.code = ID_ECALL;
               end else if (f12 == F12_MRET) begin
                  dec_in.code = ID_MRET;
               end else begin
                  dec_in.code = ID_EBREAK;
               end
            end else begin
               dec_in.code = csr_code(f3);
               dec_in.fmt  = FMT_I;
            end
         end
         default: ;
      endcase
      // unmatched encodings carry no format
      if (dec_in.code == ID_UNKNOWN) begin
         dec_in.fmt = FMT_NONE;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
         dec_ff  <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_dec   = dec_ff;

endmodule

[rtl/core/rvid_extract.sv]
module rvid_extract (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rvid_pkg::WORD_W-1:0] in_word,
   input  rvid_pkg::dec_type           in_dec,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rvid_pkg::rsp_fields_type    out_fields
);
   import rvid_pkg::*;

   logic           valid_ff;
   rsp_fields_type fields_ff;
   rsp_fields_type fields_in;
   logic           known;
   logic           uses_rd;
   logic           uses_rs1;
   logic           uses_rs2;

   assign known    = (in_dec.code != ID_UNKNOWN);
   assign uses_rd  = (in_dec.fmt == FMT_R) || (in_dec.fmt == FMT_I) ||
                     (in_dec.fmt == FMT_U) || (in_dec.fmt == FMT_J);
   assign uses_rs1 = (in_dec.fmt == FMT_R) || (in_dec.fmt == FMT_I) ||
                     (in_dec.fmt == FMT_S) || (in_dec.fmt == FMT_B);
   assign uses_rs2 = (in_dec.fmt == FMT_R) || (in_dec.fmt == FMT_S) ||
                     (in_dec.fmt == FMT_B);

   always_comb begin
      fields_in.code         = in_dec.code;
      fields_in.fmt          = in_dec.fmt;
      fields_in.major_opcode = known ? in_word[6:0] : 7'd0;
      fields_in.func3        = known ? in_word[14:12] : 3'd0;
      fields_in.func7        = known ? in_word[31:25] : 7'd0;
      fields_in.dest_reg     = uses_rd ? in_word[11:7] : 5'd0;
      fields_in.src_reg1     = uses_rs1 ? in_word[19:15] : 5'd0;
      fields_in.src_reg2     = uses_rs2 ? in_word[24:20] : 5'd0;
      unique case (in_dec.fmt)
         FMT_I: fields_in.immediate = {8'd0, in_word[31:20]};
         FMT_S: fields_in.immediate = {8'd0, in_word[31:25], in_word[11:7]};
         FMT_B: fields_in.immediate = {8'd0, in_word[31], in_word[7],
                                       in_word[30:25], in_word[11:8]};
         FMT_U: fields_in.immediate = in_word[31:12];
         FMT_J: fields_in.immediate = {in_word[31], in_word[19:12],
                                       in_word[20], in_word[30:21]};
         default: fields_in.immediate = '0;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         fields_ff <= fields_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_fields = fields_ff;

endmodule

[rtl/core/rv64i_instruction_decoder_core.sv]
// RV64I + Zicsr instruction decoder.
// req channel: one 32-bit instruction word per beat on req_tdata.
// rsp channel: one decoded beat per instruction, in order, on rsp_tdata:
//   instruction code, format, opcode, funct3, funct7, rd, rs1, rs2 and the
//   raw packed immediate bits. Unknown or unmatched encodings give an
//   all-zero beat; unused rd/rs1/rs2/immediate fields of a format are zero.
// Pipeline: three register stages (capture register, classify stage, field
//   extract/output stage); a req beat passes through them in that order,
//   holding in any stage whose successor has no room.
// Throughput: one instruction per cycle while rsp_tready stays high; every
//   stage registers a beat in each cycle in which its successor frees room.
// Reset clears the stage valid bits; no beat is presented until a new
//   instruction has passed through.
// When the receiver holds rsp_tready low the output beat holds, the
//   stages behind it fill up, and req_tready drops once all three stages
//   are occupied. Nothing is dropped or repeated.
module rv64i_instruction_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [5:0] ins_code, [8:6] format,
                                    // [15:9] major_opcode, [18:16] func3,
                                    // [25:19] func7, [30:26] dest_reg,
                                    // [35:31] src_reg1, [40:36] src_reg2,
                                    // [60:41] immediate, [63:61] zero
);
   import rvid_pkg::*;

   logic              cap_valid_ff;
   logic [WORD_W-1:0] cap_word_ff;
   logic              cap_ready;
   logic              cls_valid;
   logic              cls_ready;
   logic [WORD_W-1:0] cls_word;
   dec_type           cls_dec;
   rsp_fields_type    ext_fields;
   logic [$bits(rsp_fields_type)-1:0] ext_bits;

   assign req_tready = !cap_valid_ff || cap_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else if (req_tready) begin
         cap_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cap_word_ff <= req_tdata;
      end
   end

   rvid_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cap_valid_ff),
      .in_ready  (cap_ready),
      .in_word   (cap_word_ff),
      .out_valid (cls_valid),
      .out_ready (cls_ready),
      .out_word  (cls_word),
      .out_dec   (cls_dec)
   );

   rvid_extract u_extract (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cls_valid),
      .in_ready   (cls_ready),
      .in_word    (cls_word),
      .in_dec     (cls_dec),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_fields (ext_fields)
   );

   assign ext_bits  = ext_fields;
   assign rsp_tdata = {{(RSP_W - $bits(rsp_fields_type)){1'b0}}, ext_bits};

endmodule

[rtl/core/rvid_checker.sv]
module rvid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // unknown code carries an all-zero beat
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] == 6'd0 |-> rsp_tdata[63:6] == 58'd0)
      else $error("unknown instruction with nonzero fields");

   // R and none formats carry no immediate bits
   a_no_imm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:6] == 3'd0 || rsp_tdata[8:6] == 3'd1)
      |-> rsp_tdata[60:41] == 20'd0 && rsp_tdata[63:61] == 3'd0)
      else $error("immediate bits set for a format without immediate");

   // an idle pipeline takes a new word at once
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(req_tvalid) && !$past(rsp_tvalid) |-> req_tready)
      else $error("req_tready low with an empty pipeline");

endmodule

bind rv64i_instruction_decoder_core rvid_checker u_rvid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
